/* rtl/core/get_pkg.sv */
`timescale 1ns / 1ps

package get_pkg;

    // field widths
    localparam int OP_W   = 2;
    localparam int NODE_W = 10;
    localparam int FLAG_W = 16;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 11;

    // entry layout: {flags, dest, valid}
    localparam int ENT_W = FLAG_W + NODE_W + 1;

    // op codes
    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_DEL_ONE = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL_ALL = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_ADDED      = 3'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STAT_W-1:0] ST_REMOVED    = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [STAT_W-1:0] ST_SWEEP_DONE = 3'd5;

    // finished result handed to the output stage
    typedef struct packed {
        logic                  valid;
        logic [STAT_W-1:0]     status;
    } rsp_t;

endpackage

/* rtl/core/get_ram.sv */
`timescale 1ns / 1ps

module get_ram #(
    parameter int WIDTH  = 27,
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/get_ctrl.sv */
`timescale 1ns / 1ps

module get_ctrl #(
    parameter int NODES = 1024,
    parameter int SLOTS = 16,
    parameter int DEPTH = NODES * SLOTS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [get_pkg::OP_W-1:0]    op,
    input  logic [get_pkg::NODE_W-1:0]  src,
    input  logic [get_pkg::NODE_W-1:0]  dst,
    input  logic [get_pkg::FLAG_W-1:0]  flg,
    input  logic [get_pkg::CNT_W-1:0]   node_count,
    input  logic                        out_free,
    output get_pkg::rsp_t               rsp,
    output logic                        ram_we,
    output logic [AW-1:0]               ram_waddr,
    output logic [get_pkg::ENT_W-1:0]   ram_wdata,
    output logic [AW-1:0]               ram_raddr,
    input  logic [get_pkg::ENT_W-1:0]   ram_rdata
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = get_pkg::CNT_W;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [get_pkg::OP_W-1:0]     op_reg, op_next;
    logic [get_pkg::NODE_W-1:0]   dst_reg, dst_next;
    logic [get_pkg::FLAG_W-1:0]   flg_reg, flg_next;
    logic [AW-1:0]                addr_reg, addr_next;
    logic [SLOT_W-1:0]            slot_reg, slot_next;
    logic [CNT_W-1:0]             node_reg, node_next;
    logic [CNT_W-1:0]             limit_reg, limit_next;
    logic                         rd_vld_reg, rd_vld_next;
    logic                         rd_last_reg, rd_last_next;
    logic [AW-1:0]                rd_addr_reg, rd_addr_next;
    logic                         free_vld_reg, free_vld_next;
    logic [AW-1:0]                free_addr_reg, free_addr_next;
    logic [get_pkg::STAT_W-1:0]   status_reg, status_next;

    logic                         src_ok;
    logic [AW-1:0]                src_base;
    logic [CNT_W-1:0]             sweep_lim;
    logic                         issue;
    logic                         slot_last;
    logic                         node_last;
    logic                         ent_valid;
    logic                         hit;

    // decode of the incoming word
    assign src_ok    = 32'(src) < 32'(NODES);
    assign src_base  = AW'(32'(src) * 32'(SLOTS));
    assign sweep_lim = (32'(node_count) > 32'(NODES)) ? CNT_W'(NODES) : node_count;

    // read issue: slots of one source, or of every source below the limit
    assign issue     = (state_reg == S_SCAN) && (node_reg < limit_reg);
    assign slot_last = slot_reg == SLOT_W'(SLOTS - 1);
    assign node_last = node_reg == CNT_W'(limit_reg - CNT_W'(1));
    assign ram_raddr = addr_reg;

    // compare of the returned entry
    assign ent_valid = ram_rdata[0];
    assign hit       = ent_valid && (ram_rdata[get_pkg::NODE_W:1] == dst_reg);

    assign s_ready    = state_reg == S_IDLE;
    assign rsp.valid  = (state_reg == S_RESP) && out_free;
    assign rsp.status = status_reg;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        dst_next       = dst_reg;
        flg_next       = flg_reg;
        addr_next      = addr_reg;
        slot_next      = slot_reg;
        node_next      = node_reg;
        limit_next     = limit_reg;
        rd_vld_next    = 1'b0;
        rd_last_next   = 1'b0;
        rd_addr_next   = addr_reg;
        free_vld_next  = free_vld_reg;
        free_addr_next = free_addr_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_waddr      = rd_addr_reg;
        ram_wdata      = '0;

        unique case (state_reg)
            S_CLEAR: begin
                // wipe every entry in turn after reset
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                addr_next = addr_reg + AW'(1);
                if (addr_reg == AW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next       = op;
                    dst_next      = dst;
                    flg_next      = flg;
                    slot_next     = '0;
                    node_next     = '0;
                    free_vld_next = 1'b0;
                    addr_next     = src_base;
                    limit_next    = CNT_W'(1);
                    case (op)
                        get_pkg::OP_ADD: begin
                            if (src_ok) begin
                                state_next = S_SCAN;
                            end else begin
                                status_next = get_pkg::ST_FULL;
                                state_next  = S_RESP;
                            end
                        end
                        get_pkg::OP_DEL_ONE: begin
                            if (src_ok) begin
                                state_next = S_SCAN;
                            end else begin
                                status_next = get_pkg::ST_NOT_FOUND;
                                state_next  = S_RESP;
                            end
                        end
                        get_pkg::OP_DEL_ALL: begin
                            addr_next  = '0;
                            limit_next = sweep_lim;
                            if (sweep_lim == '0) begin
                                status_next = get_pkg::ST_SWEEP_DONE;
                                state_next  = S_RESP;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            status_next = get_pkg::ST_NOT_FOUND;
                            state_next  = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // issue next read
                if (issue) begin
                    addr_next    = addr_reg + AW'(1);
                    rd_vld_next  = 1'b1;
                    rd_last_next = slot_last && node_last;
                    if (slot_last) begin
                        slot_next = '0;
                        node_next = node_reg + CNT_W'(1);
                    end else begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
                // act on the entry read last cycle
                if (rd_vld_reg) begin
                    case (op_reg)
                        get_pkg::OP_ADD: begin
                            if (hit) begin
                                status_next = get_pkg::ST_PRESENT;
                                state_next  = S_RESP;
                            end else begin
                                if (!ent_valid && !free_vld_reg) begin
                                    free_vld_next  = 1'b1;
                                    free_addr_next = rd_addr_reg;
                                end
                                if (rd_last_reg) begin
                                    state_next = S_RESP;
                                    if (free_vld_reg || !ent_valid) begin
                                        ram_we      = 1'b1;
                                        ram_waddr   = free_vld_reg ? free_addr_reg : rd_addr_reg;
                                        ram_wdata   = {flg_reg, dst_reg, 1'b1};
                                        status_next = get_pkg::ST_ADDED;
                                    end else begin
                                        status_next = get_pkg::ST_FULL;
                                    end
                                end
                            end
                        end
                        get_pkg::OP_DEL_ONE: begin
                            if (hit) begin
                                ram_we      = 1'b1;
                                ram_wdata   = {ram_rdata[get_pkg::ENT_W-1:1], 1'b0};
                                status_next = get_pkg::ST_REMOVED;
                                state_next  = S_RESP;
                            end else if (rd_last_reg) begin
                                status_next = get_pkg::ST_NOT_FOUND;
                                state_next  = S_RESP;
                            end
                        end
                        default: begin
                            // sweep: drop every match, keep going
                            if (hit) begin
                                ram_we    = 1'b1;
                                ram_wdata = {ram_rdata[get_pkg::ENT_W-1:1], 1'b0};
                            end
                            if (rd_last_reg) begin
                                status_next = get_pkg::ST_SWEEP_DONE;
                                state_next  = S_RESP;
                            end
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            addr_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            rd_last_reg  <= 1'b0;
            free_vld_reg <= 1'b0;
            slot_reg     <= '0;
            node_reg     <= '0;
            limit_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            rd_vld_reg   <= rd_vld_next;
            rd_last_reg  <= rd_last_next;
            free_vld_reg <= free_vld_next;
            slot_reg     <= slot_next;
            node_reg     <= node_next;
            limit_reg    <= limit_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        dst_reg       <= dst_next;
        flg_reg       <= flg_next;
        rd_addr_reg   <= rd_addr_next;
        free_addr_reg <= free_addr_next;
        status_reg    <= status_next;
    end

    // no memory writes while waiting for a word
    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("entry memory written while idle");

    // a result that can leave returns the block to idle
    a_resp_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && out_free) |=> (state_reg == S_IDLE))
        else $error("result stage did not release");

    // an undefined op answers not found right away
    a_bad_op: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && op != get_pkg::OP_ADD && op != get_pkg::OP_DEL_ONE
         && op != get_pkg::OP_DEL_ALL)
        |=> (state_reg == S_RESP && status_reg == get_pkg::ST_NOT_FOUND))
        else $error("undefined op not answered as not found");

endmodule

/* rtl/core/graph_edge_table.sv */
`timescale 1ns / 1ps

// Directed edge table: each of NODES sources owns SLOTS edge slots held in one
// entry memory with a single read port, scanned one slot per cycle. An add or
// delete-one reads the slots of its source in turn (accept, slot reads, final
// compare, result); a duplicate add or a delete-one that hits slot k (counting
// from 0) stops there. A delete-all scans the slots of every source below
// min(node_count, NODES), or answers without a scan when the node count is
// zero; a bad source or undefined op also answers without a scan. A result
// waits while the output word is full and m_tready is low. One word is worked
// on at a time. After reset the block clears the whole memory with s_tready
// low; node_count writes are taken throughout.
module graph_edge_table #(
    parameter int NODES = 1024,
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,   // node_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // source_node[9:0], dest_node[19:10], edge_flags[35:20]
    input  logic [1:0]  s_tuser,       // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata        // status[2:0]
);

    localparam int DEPTH = NODES * SLOTS;
    localparam int AW    = $clog2(DEPTH);

    logic [get_pkg::CNT_W-1:0]  node_count_reg;
    logic                       m_tvalid_reg;
    logic [get_pkg::STAT_W-1:0] m_status_reg;
    logic                       out_free;
    get_pkg::rsp_t              rsp;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [get_pkg::ENT_W-1:0]  ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [get_pkg::ENT_W-1:0]  ram_rdata;

    // node count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= '0;
        end else if (cfg_wr_en) begin
            node_count_reg <= cfg_wr_data;
        end
    end

    // output word register
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (rsp.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp.valid) begin
            m_status_reg <= rsp.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_status_reg};

    get_ctrl #(
        .NODES (NODES),
        .SLOTS (SLOTS),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .op         (s_tuser),
        .src        (s_tdata[9:0]),
        .dst        (s_tdata[19:10]),
        .flg        (s_tdata[35:20]),
        .node_count (node_count_reg),
        .out_free   (out_free),
        .rsp        (rsp),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    get_ram #(
        .WIDTH  (get_pkg::ENT_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int TB_NODES = 1024;
    localparam int TB_SLOTS = 16;
    localparam int TB_DEPTH = TB_NODES * TB_SLOTS;

    // op code the block leaves undefined
    localparam logic [get_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    logic                        aclk;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [get_pkg::CNT_W-1:0]   cfg_wr_data;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [39:0]                 s_tdata;  // source_node[9:0], dest_node[19:10], edge_flags[35:20]
    logic [get_pkg::OP_W-1:0]    s_tuser;  // op
    logic                        m_tvalid;
    logic                        m_tready;
    logic [7:0]                  m_tdata;  // status[2:0]

    // shadow copy of the edge table
    logic                        slot_live  [TB_DEPTH];
    logic [get_pkg::NODE_W-1:0]  slot_dest  [TB_DEPTH];
    logic [get_pkg::FLAG_W-1:0]  slot_flags [TB_DEPTH];
    logic [get_pkg::CNT_W-1:0]   node_limit;

    logic [get_pkg::STAT_W-1:0]  status_due [$];
    int                          err_count;

    // pacing controls shared with the driver and the receiver
    bit                tx_pace;
    bit                rx_pace;
    bit                hold_request;
    int                hold_len;

    graph_edge_table #(
        .NODES (TB_NODES),
        .SLOTS (TB_SLOTS)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap(bit paced);
        int r;
        if (!paced) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // status of one command, applied to the shadow table
    function automatic logic [get_pkg::STAT_W-1:0] predict_status(
            logic [get_pkg::OP_W-1:0] op, logic [get_pkg::NODE_W-1:0] src,
            logic [get_pkg::NODE_W-1:0] dst, logic [get_pkg::FLAG_W-1:0] flg);
        int base;
        int free_slot;
        int sweep_end;
        int k;
        base = int'(src) * TB_SLOTS;
        case (op)
            get_pkg::OP_ADD: begin
                if (int'(src) >= TB_NODES) return get_pkg::ST_FULL;
                free_slot = -1;
                for (k = 0; k < TB_SLOTS; k++) begin
                    if (slot_live[base + k]) begin
                        if (slot_dest[base + k] == dst) return get_pkg::ST_PRESENT;
                    end else if (free_slot < 0) begin
                        free_slot = k;
                    end
                end
                if (free_slot < 0) return get_pkg::ST_FULL;
                slot_live[base + free_slot]  = 1'b1;
                slot_dest[base + free_slot]  = dst;
                slot_flags[base + free_slot] = flg;
                return get_pkg::ST_ADDED;
            end
            get_pkg::OP_DEL_ONE: begin
                if (int'(src) >= TB_NODES) return get_pkg::ST_NOT_FOUND;
                for (k = 0; k < TB_SLOTS; k++) begin
                    if (slot_live[base + k] && slot_dest[base + k] == dst) begin
                        slot_live[base + k] = 1'b0;
                        return get_pkg::ST_REMOVED;
                    end
                end
                return get_pkg::ST_NOT_FOUND;
            end
            get_pkg::OP_DEL_ALL: begin
                // sweep saturates at the table size
                sweep_end = (int'(node_limit) > TB_NODES) ? TB_NODES : int'(node_limit);
                for (k = 0; k < sweep_end * TB_SLOTS; k++) begin
                    if (slot_live[k] && slot_dest[k] == dst) slot_live[k] = 1'b0;
                end
                return get_pkg::ST_SWEEP_DONE;
            end
            default: return get_pkg::ST_NOT_FOUND;
        endcase
    endfunction

    // offer one command word and record its expected status once taken
    task automatic issue_edge_cmd(input logic [get_pkg::OP_W-1:0] op,
            input logic [get_pkg::NODE_W-1:0] src, input logic [get_pkg::NODE_W-1:0] dst,
            input logic [get_pkg::FLAG_W-1:0] flg);
        int gap;
        gap = pick_gap(tx_pace);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, flg, dst, src};
        do @(posedge aclk); while (!s_tready);
        status_due.push_back(predict_status(op, src, dst, flg));
    endtask

    // stop offering and wait for every outstanding status
    task automatic drain_words();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (status_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_node_count(input logic [get_pkg::CNT_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        node_limit = value;
    endtask

    // result side: random stalls, plus a long hold when requested
    initial begin : receiver
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        m_tready   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_left    = hold_len;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                stall_left = pick_gap(rx_pace);
            end
        end
    end

    // compare each status word against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (status_due.size() == 0) begin
                $display("%0t: unexpected status word, expected none, got %0d",
                         $time, m_tdata);
                err_count++;
            end else if (m_tdata !== {5'b0, status_due[0]}) begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, status_due[0], m_tdata);
                err_count++;
                void'(status_due.pop_front());
            end else begin
                void'(status_due.pop_front());
            end
        end
    end

    // undefined op, duplicate add, delete hit and miss, sweep with no nodes
    task automatic test_basic_ops();
        write_node_count(11'd0);
        issue_edge_cmd(OP_UNUSED, 10'd1023, 10'd1023, 16'hFFFF);
        issue_edge_cmd(get_pkg::OP_ADD, 10'd0, 10'd0, 16'h0000);
        issue_edge_cmd(get_pkg::OP_ADD, 10'd0, 10'd0, 16'hFFFF);
        issue_edge_cmd(get_pkg::OP_DEL_ONE, 10'd0, 10'd5, 16'h0000);
        issue_edge_cmd(get_pkg::OP_DEL_ONE, 10'd0, 10'd0, 16'hFFFF);
        issue_edge_cmd(get_pkg::OP_DEL_ALL, 10'd1023, 10'd1023, 16'h5A5A);
        drain_words();
    endtask

    // fill the top source completely, overflow it, free one slot
    task automatic test_full_list();
        int k;
        for (k = 0; k < TB_SLOTS; k++)
            issue_edge_cmd(get_pkg::OP_ADD, 10'd1023, 10'(1008 + k), 16'($urandom));
        issue_edge_cmd(get_pkg::OP_ADD, 10'd1023, 10'd0, 16'hFFFF);
        issue_edge_cmd(get_pkg::OP_DEL_ONE, 10'd1023, 10'd1015, 16'h0000);
        drain_words();
    endtask

    // sweeps over the whole table, at and above the table size
    task automatic test_wide_sweeps();
        write_node_count(11'd1024);
        issue_edge_cmd(get_pkg::OP_DEL_ALL, 10'd0, 10'd1023, 16'h0000);
        issue_edge_cmd(get_pkg::OP_ADD, 10'd1023, 10'd1023, 16'h8001);
        drain_words();
        write_node_count(11'd2047);
        issue_edge_cmd(get_pkg::OP_DEL_ALL, 10'd1023, 10'd1008, 16'hFFFF);
        issue_edge_cmd(get_pkg::OP_DEL_ONE, 10'd1023, 10'd1008, 16'h0000);
        drain_words();
    endtask

    // result side held off while commands keep coming
    task automatic test_output_backpressure();
        int k;
        tx_pace = 1'b0;
        rx_pace = 1'b0;
        write_node_count(11'd8);
        hold_len     = 300;
        hold_request = 1'b1;
        for (k = 0; k < 12; k++)
            issue_edge_cmd((k % 3 == 2) ? get_pkg::OP_DEL_ONE : get_pkg::OP_ADD, 10'd3,
                           10'($urandom_range(5)), 16'($urandom));
        drain_words();
    endtask

    // mixed traffic on a few busy sources, with some full-range noise
    task automatic test_random_traffic();
        logic [get_pkg::CNT_W-1:0]  phase_count [8];
        logic [get_pkg::OP_W-1:0]   op;
        logic [get_pkg::NODE_W-1:0] src;
        logic [get_pkg::NODE_W-1:0] dst;
        int                         phase;
        int                         i;
        int                         r;
        phase_count = '{11'd8, 11'd1, 11'd0, 11'd16, 11'd40, 11'd2, 11'd12, 11'd8};
        phase_count[5] = 11'($urandom_range(32, 2));
        for (phase = 0; phase < 8; phase++) begin
            write_node_count(phase_count[phase]);
            tx_pace = phase[0];
            rx_pace = phase[1];
            for (i = 0; i < 100; i++) begin
                r = $urandom_range(99);
                if (r < 50)      op = get_pkg::OP_ADD;
                else if (r < 80) op = get_pkg::OP_DEL_ONE;
                else if (r < 95) op = get_pkg::OP_DEL_ALL;
                else             op = OP_UNUSED;
                src = ($urandom_range(9) == 0) ? 10'($urandom_range(1023))
                                               : 10'($urandom_range(7));
                dst = ($urandom_range(7) == 0) ? 10'($urandom_range(1023))
                                               : 10'($urandom_range(19));
                issue_edge_cmd(op, src, dst, 16'($urandom));
            end
            drain_words();
        end
    endtask

    initial begin
        int k;
        err_count    = 0;
        tx_pace      = 1'b1;
        rx_pace      = 1'b1;
        hold_request = 1'b0;
        hold_len     = 0;
        node_limit   = '0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        for (k = 0; k < TB_DEPTH; k++) slot_live[k] = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_basic_ops();
        test_full_list();
        test_wide_sweeps();
        test_output_backpressure();
        test_random_traffic();

        drain_words();
        repeat (64) @(posedge aclk);
        if (status_due.size() != 0) begin
            $display("%0t: %0d status words never arrived", $time, status_due.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // run limit
    initial begin
        #6000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
